// ===== rtl/battery_voltage_slew_filter_unit_defines.svh =====
// Assertion macros for the battery voltage slew filter.
// Included by the top level; no other dependencies.
`ifndef BATTERY_VOLTAGE_SLEW_FILTER_UNIT_DEFINES_SVH
`define BATTERY_VOLTAGE_SLEW_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BVSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvsf assertion failed");
`define BVSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvsf assertion failed");
`else
`define BVSF_ASSERT_SAME(label, ante, cons)
`define BVSF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/bvsf_pkg.sv =====
// Shared types, constants and the divide-by-ten helper of the slew filter.
// No dependencies.
package bvsf_pkg;

    typedef logic [13:0]        mv_t;
    typedef logic [7:0]         period_t;
    typedef logic [9:0]         lim_val_t;
    typedef logic [12:0]        prod_t;
    typedef logic [4:0]         factor_t;
    typedef logic signed [15:0] diff_t;

    typedef struct packed {
        lim_val_t up;
        lim_val_t dn;
    } lim_t;

    localparam factor_t CHG_UP_FACTOR = 5'd12;
    localparam factor_t CHG_DN_FACTOR = 5'd20;
    localparam factor_t LVL_HI_FACTOR = 5'd15;
    localparam factor_t LVL_MID_FACTOR = 5'd12;
    localparam factor_t LVL_LO_FACTOR = 5'd8;

    localparam mv_t LVL_HI_MV  = 14'd3800;
    localparam mv_t LVL_MID_MV = 14'd3600;
    localparam mv_t FLOOR_MV   = 14'd3300;
    localparam mv_t CEIL_MV    = 14'd16383;

    localparam diff_t HALVE_ABOVE = -16'sd6;
    localparam diff_t MAG_BIG     = 16'sd30;
    localparam diff_t MAG_MID     = 16'sd10;

    localparam logic [13:0] DIV10_RECIP = 14'd6554;

    // floor(x / 10) for x below 8192
    function automatic lim_val_t div10(input prod_t x);
        logic [27:0] p;
        begin
            p = {15'd0, x} * {14'd0, DIV10_RECIP};
            return p[25:16];
        end
    endfunction

endpackage

// ===== rtl/bvsf_limit.sv =====
// Clamps the sample period and forms the rise and fall limits for one item.
// Depends on bvsf_pkg.
module bvsf_limit #(
    parameter int MAX_PERIOD_S = 60
) (
    input  bvsf_pkg::period_t period,
    input  bvsf_pkg::mv_t     filt,
    input  logic              charging,
    output bvsf_pkg::lim_t    lim
);
    import bvsf_pkg::*;

    localparam period_t MAX_T = period_t'(MAX_PERIOD_S);

    period_t t;
    factor_t dn_factor;
    prod_t   up_prod;
    prod_t   dn_prod;

    always_comb
    begin
        if (period == 8'd0)
            t = 8'd1;
        else if (period > MAX_T)
            t = MAX_T;
        else
            t = period;

        if (charging)
            dn_factor = CHG_DN_FACTOR;
        else if (filt > LVL_HI_MV)
            dn_factor = LVL_HI_FACTOR;
        else if (filt > LVL_MID_MV)
            dn_factor = LVL_MID_FACTOR;
        else
            dn_factor = LVL_LO_FACTOR;

        up_prod = {5'd0, t} * {8'd0, CHG_UP_FACTOR};
        dn_prod = {5'd0, t} * {8'd0, dn_factor};
        lim.up  = div10(up_prod);
        lim.dn  = div10(dn_prod);
    end

endmodule

// ===== rtl/bvsf_core.sv =====
// Next filter value from the stored filter, one sample and the limits.
// Depends on bvsf_pkg.
module bvsf_core (
    input  bvsf_pkg::mv_t  filt,
    input  bvsf_pkg::mv_t  sample,
    input  logic           charging,
    input  bvsf_pkg::lim_t lim,
    output bvsf_pkg::mv_t  filt_next
);
    import bvsf_pkg::*;

    diff_t      d;
    diff_t      d_lim;
    diff_t      up_s;
    diff_t      dn_s;
    diff_t      mag;
    diff_t      step;
    diff_t      sum;
    logic [1:0] sh;

    always_comb
    begin
        up_s = diff_t'({6'd0, lim.up});
        dn_s = -diff_t'({6'd0, lim.dn});
        d    = diff_t'({2'b00, sample}) - diff_t'({2'b00, filt});

        d_lim = d;
        if (charging)
        begin
            if (d_lim > up_s)
                d_lim = up_s;
        end
        else if (d_lim > HALVE_ABOVE)
        begin
            d_lim = d_lim >>> 1;
        end
        if (d_lim < dn_s)
            d_lim = dn_s;

        mag = (d_lim < 16'sd0) ? -d_lim : d_lim;
        if (mag > MAG_BIG)
            sh = 2'd1;
        else if (mag > MAG_MID)
            sh = 2'd2;
        else
            sh = 2'd3;

        step = d_lim >>> sh;
        sum  = diff_t'({2'b00, filt}) + step;

        if (sum < diff_t'({2'b00, FLOOR_MV}))
            filt_next = FLOOR_MV;
        else if (sum > diff_t'({2'b00, CEIL_MV}))
            filt_next = CEIL_MV;
        else
            filt_next = sum[13:0];
    end

endmodule

// ===== rtl/battery_voltage_slew_filter_unit.sv =====
// Battery voltage slew filter: samples pass the input register, then the filter register.
// One item per cycle unless out_stall holds; the filter register is updated in the same cycle
// the result register loads, so each item sees the previous item's value.
// One item is held in the input register while a result waits on a stall.
// Reset (rst_n low, async) clears valid flags, filter to 0, unprimed, period to 1.
`include "battery_voltage_slew_filter_unit_defines.svh"

module battery_voltage_slew_filter_unit #(
    parameter int MAX_PERIOD_S = 60
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  bvsf_pkg::period_t cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  bvsf_pkg::mv_t     sample_mv,
    input  logic              is_charging,
    output logic              out_valid,
    input  logic              out_stall,
    output bvsf_pkg::mv_t     filtered_mv
);
    import bvsf_pkg::*;

    period_t period_reg;
    logic    in_valid_reg, in_valid_next;
    mv_t     sample_reg;
    logic    charging_reg;
    mv_t     filter_reg, filter_next;
    logic    primed_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    in_take;
    lim_t    lim;
    mv_t     core_next;

    bvsf_limit #(
        .MAX_PERIOD_S (MAX_PERIOD_S)
    ) u_limit (
        .period   (period_reg),
        .filt     (filter_reg),
        .charging (charging_reg),
        .lim      (lim)
    );

    bvsf_core u_core (
        .filt      (filter_reg),
        .sample    (sample_reg),
        .charging  (charging_reg),
        .lim       (lim),
        .filt_next (core_next)
    );

    always_comb
    begin
        advance  = in_valid_reg && (!out_valid_reg || !out_stall);
        in_stall = in_valid_reg && !advance;
        in_take  = in_valid && !in_stall;

        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        filter_next = primed_reg ? core_next : sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= 8'd1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filter_reg    <= '0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                period_reg <= cfg_wr_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                filter_reg <= filter_next;
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg   <= sample_mv;
            charging_reg <= is_charging;
        end
    end

    assign out_valid   = out_valid_reg;
    assign filtered_mv = filter_reg;

    `BVSF_ASSERT_NEXT(a_floor_held, advance && primed_reg, filter_reg >= FLOOR_MV)
    `BVSF_ASSERT_NEXT(a_first_pass, advance && !primed_reg, filter_reg == $past(sample_reg))
    `BVSF_ASSERT_SAME(a_stall_cause, in_stall, out_valid_reg && out_stall)
    `BVSF_ASSERT_NEXT(a_result_follows, advance, out_valid_reg && primed_reg)

endmodule

// ===== sim/battery_voltage_slew_filter_unit_test.sv =====
// Self-checking test of battery_voltage_slew_filter_unit: random and directed samples under
// random stalls, checked against an in-bench filter prediction held by a scoreboard class.
// Depends on bvsf_pkg and the battery_voltage_slew_filter_unit RTL.
`timescale 1ns / 1ps

module battery_voltage_slew_filter_unit_test;
    import bvsf_pkg::*;

    localparam int MAX_PERIOD = 60;

    class filter_scoreboard;
        mv_t     pending_mv[$];
        mv_t     filter_mv;
        bit      primed;
        period_t period;
        int      errors;

        function new();
            filter_mv = '0;
            primed    = 1'b0;
            period    = 8'd1;
            errors    = 0;
        endfunction

        function void set_period(input period_t p);
            period = p;
        endfunction

        function void note_sample(input mv_t sample, input logic charging);
            int t;
            int d;
            int filt;
            int lim;
            int lvl;
            int mag;
            int sh;
            if (!primed)
            begin
                filter_mv = sample;
                primed    = 1'b1;
                pending_mv.push_back(filter_mv);
                return;
            end
            t = int'(period);
            if (t < 1)
                t = 1;
            if (t > MAX_PERIOD)
                t = MAX_PERIOD;
            filt = int'(filter_mv);
            d    = int'(sample) - filt;
            if (charging)
            begin
                lim = (12 * t) / 10;
                if (d > lim)
                    d = lim;
                lim = (20 * t) / 10;
                if (d < -lim)
                    d = -lim;
            end
            else
            begin
                if (filt > 3800)
                    lvl = 15;
                else if (filt > 3600)
                    lvl = 12;
                else
                    lvl = 8;
                if (d > -6)
                    d = d >>> 1;
                lim = (lvl * t) / 10;
                if (d < -lim)
                    d = -lim;
            end
            mag = (d < 0) ? -d : d;
            if (mag > 30)
                sh = 1;
            else if (mag > 10)
                sh = 2;
            else
                sh = 3;
            filt = filt + (d >>> sh);
            if (filt < 3300)
                filt = 3300;
            if (filt > 16383)
                filt = 16383;
            filter_mv = mv_t'(filt);
            pending_mv.push_back(filter_mv);
        endfunction

        function void check_filtered(input mv_t got);
            mv_t want;
            if (pending_mv.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: filtered_mv=%0d", got);
                return;
            end
            want = pending_mv.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: filtered_mv expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_wr_en = 1'b0;
    period_t cfg_wr_data = '0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    mv_t     sample_mv = '0;
    logic    is_charging = 1'b0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    mv_t     filtered_mv;

    filter_scoreboard sb = new();
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int target_mv = 3700;

    battery_voltage_slew_filter_unit #(
        .MAX_PERIOD_S(MAX_PERIOD)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_mv(sample_mv),
        .is_charging(is_charging),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .filtered_mv(filtered_mv)
    );

    always #5 clk = ~clk;

    function automatic mv_t clamp_mv(input int v);
        if (v < 0)
            return '0;
        if (v > 16383)
            return 14'd16383;
        return mv_t'(v);
    endfunction

    task automatic send_sample(input mv_t s, input logic chg);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_mv   <= s;
        is_charging <= chg;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note_sample(s, chg);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_mv.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic change_period(input period_t p);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_period(p);
    endtask

    task automatic send_rel(input int off, input logic chg);
        send_sample(clamp_mv(int'(sb.filter_mv) + off), chg);
    endtask

    task automatic run_phase(input int n);
        int r;
        int v;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) == 0)
                target_mv = $urandom_range(3150, 4450);
            else
                target_mv = target_mv + $urandom_range(0, 20) - 10;
            if (target_mv < 3150)
                target_mv = 3150;
            if (target_mv > 4450)
                target_mv = 4450;
            r = $urandom_range(0, 99);
            if (r < 8)
                v = $urandom_range(0, 16383);
            else if (r < 20)
                v = int'(sb.filter_mv) + $urandom_range(0, 80) - 40;
            else
                v = target_mv + $urandom_range(0, 50) - 25;
            send_sample(clamp_mv(v), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int hold;
        int cyc;
        hold = 0;
        cyc  = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            if (out_valid && !out_stall)
            begin
                sb.check_filtered(filtered_mv);
                hold = recv_burst ? 0 : $urandom_range(0, 4);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // period 1: first sample below floor, tiny limits
        send_sample(14'd2000, 1'b0);
        send_sample(14'd16383, 1'b1);
        send_sample(14'd0, 1'b0);
        send_sample(14'd16383, 1'b0);
        send_sample(14'd3300, 1'b1);
        send_sample(14'd0, 1'b1);

        change_period(8'd60);
        send_rel(10, 1'b1);
        send_rel(11, 1'b1);
        send_rel(30, 1'b1);
        send_rel(31, 1'b1);
        send_rel(-5, 1'b0);
        send_rel(-6, 1'b0);
        send_rel(-7, 1'b0);
        send_rel(-11, 1'b1);
        send_rel(-31, 1'b1);
        send_sample(14'd16383, 1'b1);
        send_sample(14'd0, 1'b1);
        send_sample(14'd16383, 1'b0);
        send_sample(14'd0, 1'b0);
        send_sample(14'd3700, 1'b0);
        send_sample(14'd0, 1'b0);

        change_period(8'd0);
        run_phase(205);
        change_period(8'd255);
        run_phase(205);
        change_period(8'd60);
        run_phase(205);
        change_period(8'd61);
        run_phase(205);
        change_period(8'd1);
        run_phase(205);
        change_period(8'd7);
        run_phase(205);
        change_period(period_t'($urandom_range(2, 59)));
        run_phase(205);

        drain();
        repeat (2) @(posedge clk);
        if (sb.errors == 0 && sb.pending_mv.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
